>>> rtl/core/gmdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmdc_pkg
// Shared types, codes and helpers of the depth-first maze carver.
// ----------------------------------------------------------------------------
package gmdc_pkg;

  localparam int DRAW_W    = 15;
  localparam int COORD_W   = 6;
  localparam int DIM_REG_W = 7;
  localparam int CFG_IDX_W = 2;

  typedef logic [1:0]           action_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam action_t ACT_CARVE    = 2'd0;
  localparam action_t ACT_BACK     = 2'd1;
  localparam action_t ACT_FINISHED = 2'd2;
  localparam action_t ACT_NO_MOVE  = 2'd3;

  localparam cfg_idx_t REG_ROWS = 2'd0;
  localparam cfg_idx_t REG_COLS = 2'd1;

  // Remainder by three: base-four digits sum to the same residue.
  function automatic logic [1:0] mod3_draw(input logic [DRAW_W-1:0] v);
    logic [15:0] x;
    logic [4:0]  s;
    logic [2:0]  t;
    x = {1'b0, v};
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 5'(x[2*i +: 2]);
    end
    t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    if (t >= 3'd6) begin
      t = t - 3'd6;
    end else if (t >= 3'd3) begin
      t = t - 3'd3;
    end
    return t[1:0];
  endfunction

endpackage

>>> rtl/core/grid_maze_dfs_carver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_maze_dfs_carver
// Recursive-backtracker maze carving, one step per input transfer.
// ----------------------------------------------------------------------------
// After reset the block sweeps the visited-cell memory, one cell per cycle,
// and takes no input during that pass; configuration writes are taken at
// any time. A step is paced by the single read port of the visited memory,
// which is read once for each of the four neighbors, and a backtrack step
// adds an extra stack read; a result may also wait for the output side.
// A new input is taken while the previous result still sits in the output
// register.
module grid_maze_dfs_carver
  import gmdc_pkg::*;
#(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [DRAW_W-1:0]    random_draw,
  output logic                 out_valid,
  input  logic                 out_ready,
  output action_t              action,
  output logic [COORD_W-1:0]   from_row,
  output logic [COORD_W-1:0]   from_col,
  output logic [COORD_W-1:0]   to_row,
  output logic [COORD_W-1:0]   to_col,
  output logic                 done_res,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  cfg_idx_t             cfg_index,
  input  logic [DIM_REG_W-1:0] cfg_data
);

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int SPW   = $clog2(CELLS + 1);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int RDW   = ($clog2(MAX_ROWS + 1) > DIM_REG_W) ? $clog2(MAX_ROWS + 1) : DIM_REG_W;
  localparam int CDW   = ($clog2(MAX_COLS + 1) > DIM_REG_W) ? $clog2(MAX_COLS + 1) : DIM_REG_W;
  localparam int RX    = RDW + 1;
  localparam int CX    = CDW + 1;
  localparam int MW    = RDW + CDW;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RT    = 3'd2;
  localparam logic [2:0] S_DN    = 3'd3;
  localparam logic [2:0] S_LF    = 3'd4;
  localparam logic [2:0] S_DEC   = 3'd5;
  localparam logic [2:0] S_POP   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                              input logic [CW-1:0] c);
    return AW'(r) * AW'(MAX_COLS) + AW'(c);
  endfunction

  // Control state
  logic [2:0]           state;
  logic [AW-1:0]        clr_addr;
  logic [SPW-1:0]       stack_depth;
  logic [RW-1:0]        cur_row;
  logic [CW-1:0]        cur_col;
  logic [SPW-1:0]       visited_total;
  logic                 finished_flag;
  logic [DIM_REG_W-1:0] grid_rows;
  logic [DIM_REG_W-1:0] grid_cols;

  // Per-step payload
  logic [DRAW_W-1:0]    draw_q;
  logic [1:0]           draw_mod3;
  logic [COORD_W-1:0]   from_row_q;
  logic [COORD_W-1:0]   from_col_q;
  logic                 up_free;
  logic                 rt_free;
  logic                 dn_free;
  action_t              act_q;
  logic [MW-1:0]        cells;

  // Memory ports
  logic                 vis_we;
  logic [AW-1:0]        vis_waddr;
  logic                 vis_wdata;
  logic                 vis_re;
  logic [AW-1:0]        vis_raddr;
  logic                 vis_rdata;
  logic                 stk_we;
  logic [AW-1:0]        stk_waddr;
  logic [RW+CW-1:0]     stk_wdata;
  logic                 stk_re;
  logic [AW-1:0]        stk_raddr;
  logic [RW+CW-1:0]     stk_rdata;

  // Grid limits and neighbor range checks
  logic [RDW-1:0] rows_c;
  logic [CDW-1:0] cols_c;
  logic [RX-1:0]  fr_x;
  logic [RX-1:0]  rows_x;
  logic [CX-1:0]  fc_x;
  logic [CX-1:0]  cols_x;
  logic           up_ok;
  logic           rt_ok;
  logic           dn_ok;
  logic           lf_ok;

  always_comb begin
    if (grid_rows == '0) begin
      rows_c = RDW'(1);
    end else if (RDW'(grid_rows) > RDW'(MAX_ROWS)) begin
      rows_c = RDW'(MAX_ROWS);
    end else begin
      rows_c = RDW'(grid_rows);
    end
    if (grid_cols == '0) begin
      cols_c = CDW'(1);
    end else if (CDW'(grid_cols) > CDW'(MAX_COLS)) begin
      cols_c = CDW'(MAX_COLS);
    end else begin
      cols_c = CDW'(grid_cols);
    end
  end

  assign fr_x   = RX'(cur_row);
  assign rows_x = RX'(rows_c);
  assign fc_x   = CX'(cur_col);
  assign cols_x = CX'(cols_c);

  // A neighbor above or to the left is in the grid when the current
  // coordinate does not exceed the grid size, since it is one less.
  assign up_ok = (cur_row != '0) && (fr_x <= rows_x) && (fc_x < cols_x);
  assign rt_ok = (fr_x < rows_x) && ((fc_x + CX'(1)) < cols_x);
  assign dn_ok = ((fr_x + RX'(1)) < rows_x) && (fc_x < cols_x);
  assign lf_ok = (cur_col != '0) && (fc_x <= cols_x) && (fr_x < rows_x);

  logic [RW-1:0] up_row;
  logic [RW-1:0] dn_row;
  logic [CW-1:0] rt_col;
  logic [CW-1:0] lf_col;

  assign up_row = cur_row - RW'(1);
  assign dn_row = cur_row + RW'(1);
  assign rt_col = cur_col + CW'(1);
  assign lf_col = cur_col - CW'(1);

  // Decision logic, used in S_DEC when the left neighbor's bit arrives.
  logic [3:0]    cand;
  logic [2:0]    cand_cnt;
  logic [1:0]    pick;
  logic [1:0]    sel_dir;
  logic [1:0]    seen;
  logic          sel_found;
  logic [RW-1:0] next_row;
  logic [CW-1:0] next_col;
  logic          fin;

  assign cand     = {lf_ok & ~vis_rdata, dn_free, rt_free, up_free};
  assign cand_cnt = 3'($countones(cand));
  assign fin      = MW'(visited_total) >= cells;

  always_comb begin
    case (cand_cnt)
      3'd2:    pick = {1'b0, draw_q[0]};
      3'd3:    pick = draw_mod3;
      3'd4:    pick = draw_q[1:0];
      default: pick = 2'd0;
    endcase
  end

  // Candidates are ordered up, right, down, left; take the pick-th one.
  always_comb begin
    sel_dir   = 2'd0;
    seen      = 2'd0;
    sel_found = 1'b0;
    for (int d = 0; d < 4; d++) begin
      if (cand[d] && !sel_found) begin
        if (seen == pick) begin
          sel_dir   = 2'(d);
          sel_found = 1'b1;
        end else begin
          seen = seen + 2'd1;
        end
      end
    end
  end

  always_comb begin
    case (sel_dir)
      2'd0: begin
        next_row = up_row;
        next_col = cur_col;
      end
      2'd1: begin
        next_row = cur_row;
        next_col = rt_col;
      end
      2'd2: begin
        next_row = dn_row;
        next_col = cur_col;
      end
      default: begin
        next_row = cur_row;
        next_col = lf_col;
      end
    endcase
  end

  logic carve;
  logic back;

  assign carve = (state == S_DEC) && !fin && (cand_cnt != '0);
  assign back  = (state == S_DEC) && !fin && (cand_cnt == '0) && (stack_depth != '0);

  // Memory port control
  always_comb begin
    vis_we    = 1'b0;
    vis_waddr = clr_addr;
    vis_wdata = (clr_addr == '0);
    if (state == S_CLEAR) begin
      vis_we = 1'b1;
    end else if (carve) begin
      vis_we    = 1'b1;
      vis_waddr = cell_addr(next_row, next_col);
      vis_wdata = 1'b1;
    end
  end

  always_comb begin
    vis_re    = 1'b0;
    vis_raddr = '0;
    case (state)
      S_IDLE: begin
        vis_re    = in_valid;
        vis_raddr = up_ok ? cell_addr(up_row, cur_col) : '0;
      end
      S_RT: begin
        vis_re    = 1'b1;
        vis_raddr = rt_ok ? cell_addr(cur_row, rt_col) : '0;
      end
      S_DN: begin
        vis_re    = 1'b1;
        vis_raddr = dn_ok ? cell_addr(dn_row, cur_col) : '0;
      end
      S_LF: begin
        vis_re    = 1'b1;
        vis_raddr = lf_ok ? cell_addr(cur_row, lf_col) : '0;
      end
      default: begin
        vis_re    = 1'b0;
        vis_raddr = '0;
      end
    endcase
  end

  assign stk_we    = carve && (stack_depth != SPW'(CELLS));
  assign stk_waddr = stack_depth[AW-1:0];
  assign stk_wdata = {cur_row, cur_col};
  assign stk_re    = back;
  assign stk_raddr = AW'(stack_depth - SPW'(1));

  gmdc_ram #(
    .WIDTH(1),
    .DEPTH(CELLS)
  ) u_visited (
    .clk    (clk),
    .wr_en  (vis_we),
    .wr_addr(vis_waddr),
    .wr_data(vis_wdata),
    .rd_en  (vis_re),
    .rd_addr(vis_raddr),
    .rd_data(vis_rdata)
  );

  gmdc_ram #(
    .WIDTH(RW + CW),
    .DEPTH(CELLS)
  ) u_stack (
    .clk    (clk),
    .wr_en  (stk_we),
    .wr_addr(stk_waddr),
    .wr_data(stk_wdata),
    .rd_en  (stk_re),
    .rd_addr(stk_raddr),
    .rd_data(stk_rdata)
  );

  logic out_free;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      stack_depth   <= '0;
      cur_row       <= '0;
      cur_col       <= '0;
      visited_total <= SPW'(1);
      finished_flag <= 1'b0;
      out_valid     <= 1'b0;
      grid_rows     <= DIM_REG_W'(16);
      grid_cols     <= DIM_REG_W'(16);
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROWS: grid_rows <= cfg_data;
          REG_COLS: grid_cols <= cfg_data;
          default:  ;
        endcase
      end
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(CELLS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            state <= S_RT;
          end
        end
        S_RT:  state <= S_DN;
        S_DN:  state <= S_LF;
        S_LF:  state <= S_DEC;
        S_DEC: begin
          if (fin) begin
            finished_flag <= 1'b1;
            state         <= S_OUT;
          end else if (carve) begin
            if (stk_we) begin
              stack_depth <= stack_depth + SPW'(1);
            end
            cur_row       <= next_row;
            cur_col       <= next_col;
            visited_total <= visited_total + SPW'(1);
            state         <= S_OUT;
          end else if (back) begin
            stack_depth <= stack_depth - SPW'(1);
            state       <= S_POP;
          end else begin
            state <= S_OUT;
          end
        end
        S_POP: begin
          cur_row <= stk_rdata[RW+CW-1:CW];
          cur_col <= stk_rdata[CW-1:0];
          state   <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    cells <= MW'(rows_c) * MW'(cols_c);
    if (state == S_IDLE && in_valid) begin
      draw_q     <= random_draw;
      draw_mod3  <= mod3_draw(random_draw);
      from_row_q <= COORD_W'(cur_row);
      from_col_q <= COORD_W'(cur_col);
    end
    if (state == S_RT) begin
      up_free <= up_ok & ~vis_rdata;
    end
    if (state == S_DN) begin
      rt_free <= rt_ok & ~vis_rdata;
    end
    if (state == S_LF) begin
      dn_free <= dn_ok & ~vis_rdata;
    end
    if (state == S_DEC) begin
      if (fin) begin
        act_q <= ACT_FINISHED;
      end else if (carve) begin
        act_q <= ACT_CARVE;
      end else if (back) begin
        act_q <= ACT_BACK;
      end else begin
        act_q <= ACT_NO_MOVE;
      end
    end
    if (state == S_OUT && out_free) begin
      action   <= act_q;
      from_row <= from_row_q;
      from_col <= from_col_q;
      to_row   <= COORD_W'(cur_row);
      to_col   <= COORD_W'(cur_col);
      done_res <= finished_flag;
    end
  end

endmodule

>>> rtl/core/gmdc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmdc_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module gmdc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/gmdc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmdc_checker
// Port-level checks on the maze carver's result stream.
// ----------------------------------------------------------------------------
module gmdc_checker
  import gmdc_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_ready,
  input action_t              action,
  input logic [COORD_W-1:0]   from_row,
  input logic [COORD_W-1:0]   from_col,
  input logic [COORD_W-1:0]   to_row,
  input logic [COORD_W-1:0]   to_col,
  input logic                 done_res
);

  // Set once a finished result has been transferred; sticky until reset.
  logic seen_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_done <= 1'b0;
    end else if (out_valid && out_ready && done_res) begin
      seen_done <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(action) && $stable(to_row)
      && $stable(to_col) && $stable(from_row) && $stable(from_col))
    else $error("result changed while stalled");

  // A larger grid may let the walk carve on, but the done flag stays set.
  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && seen_done |-> done_res)
    else $error("done flag dropped after finish");

  a_finish_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && (action == ACT_FINISHED) |-> done_res)
    else $error("finished report without done flag");

  a_stay_put: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((action == ACT_FINISHED) || (action == ACT_NO_MOVE))
      |-> (to_row == from_row) && (to_col == from_col))
    else $error("cell moved on a step without a move");

  a_carve_adjacent: assert property (@(posedge clk) disable iff (rst)
    out_valid && (action == ACT_CARVE) |->
      ((to_row == from_row) && ((to_col == from_col + 6'd1) || (from_col == to_col + 6'd1)))
      || ((to_col == from_col) && ((to_row == from_row + 6'd1) || (from_row == to_row + 6'd1))))
    else $error("carve to a cell that is not a neighbor");

endmodule

bind grid_maze_dfs_carver gmdc_checker u_gmdc_checker (.*);
